>>> sv/dqle_pkg.sv
// ----------------------------------------------------------------------------
// dqle_pkg
// shared types and constants of the dns question name encoder
// ----------------------------------------------------------------------------
package dqle_pkg;

  localparam int MAX_LABEL = 32;
  localparam int IDX_W     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CNT_W     = $clog2(MAX_LABEL + 1);
  localparam int PADDR_W   = 3;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic REG_QTYPE  = 1'b0;
  localparam logic REG_QCLASS = 1'b1;

  localparam logic [15:0] QTYPE_A   = 16'd1;
  localparam logic [15:0] QCLASS_IN = 16'd1;

  localparam logic [1:0] FOOT_TYPE_HI  = 2'd0;
  localparam logic [1:0] FOOT_TYPE_LO  = 2'd1;
  localparam logic [1:0] FOOT_CLASS_HI = 2'd2;
  localparam logic [1:0] FOOT_CLASS_LO = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] name_char;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
    logic       label_overflow;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LEN  = 5'b00010,
    S_CHAR = 5'b00100,
    S_TERM = 5'b01000,
    S_FOOT = 5'b10000
  } state_t;

endpackage

>>> sv/dns_qname_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_qname_label_encoder
// dotted domain name in, dns question record in wire format out
// ----------------------------------------------------------------------------
// A name character is taken and produces nothing; it is held in a
// 32-entry label buffer, and characters past the buffer size are dropped with
// a sticky overflow flag. A dot holding n buffered characters keeps the request
// side stalled while the length byte and the characters leave; an end-of-name
// request sends the length byte and the characters (none when the label is
// empty), then the zero terminator and the big-endian type and class. Every
// result byte passes through one sequencer and one output register, so the
// output rate is one byte per cycle while the response side does not stall.
// ----------------------------------------------------------------------------
module dns_qname_label_encoder import dqle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t           state, state_next;
  logic [7:0]       label_buffer [MAX_LABEL];
  logic [CNT_W-1:0] label_count;
  logic             overflow_seen;
  logic [IDX_W-1:0] idx;
  logic [1:0]       foot_idx;
  logic             end_mode;
  logic             emit_ovf;
  logic [15:0]      type_code;
  logic [15:0]      class_code;

  logic             req_fire;
  logic             out_free;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             label_done;
  logic             cfg_wr;

  assign pready    = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign emit      = out_free && (state != S_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign label_done = (CNT_W'({1'b0, idx}) + CNT_W'(1)) == label_count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      type_code  <= QTYPE_A;
      class_code <= QCLASS_IN;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_QTYPE:  type_code  <= pwdata[15:0];
        REG_QCLASS: class_code <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_QTYPE:  prdata = {16'd0, type_code};
      REG_QCLASS: prdata = {16'd0, class_code};
      default:    prdata = 32'd0;
    endcase
  end

  // byte selection
  always_comb begin
    emit_byte = 8'd0;
    emit_last = 1'b0;
    unique case (state)
      S_LEN:  emit_byte = 8'(label_count);
      S_CHAR: emit_byte = label_buffer[idx];
      S_TERM: emit_byte = 8'd0;
      S_FOOT: begin
        case (foot_idx)
          FOOT_TYPE_HI:  emit_byte = type_code[15:8];
          FOOT_TYPE_LO:  emit_byte = type_code[7:0];
          FOOT_CLASS_HI: emit_byte = class_code[15:8];
          default: begin
            emit_byte = class_code[7:0];
            emit_last = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req_data.cmd == CMD_END) begin
            state_next = (label_count != '0) ? S_LEN : S_TERM;
          end else if (req_data.name_char == DOT_CHAR) begin
            state_next = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (emit) begin
          if (label_count != '0) state_next = S_CHAR;
          else if (end_mode)     state_next = S_TERM;
          else                   state_next = S_IDLE;
        end
      end
      S_CHAR: begin
        if (emit && label_done) state_next = end_mode ? S_TERM : S_IDLE;
      end
      S_TERM: begin
        if (emit) state_next = S_FOOT;
      end
      S_FOOT: begin
        if (emit && emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      label_count   <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      foot_idx      <= '0;
      end_mode      <= 1'b0;
      emit_ovf      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (req_fire) begin
        idx <= '0;
        if (req_data.cmd == CMD_END) begin
          end_mode <= 1'b1;
          emit_ovf <= overflow_seen;
        end else if (req_data.name_char == DOT_CHAR) begin
          end_mode <= 1'b0;
          emit_ovf <= 1'b0;
        end else if (label_count < CNT_W'(MAX_LABEL)) begin
          label_count <= label_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      if (emit) begin
        rsp_valid <= 1'b1;
        if (state == S_LEN && label_count == '0) label_count <= '0;
        if (state == S_CHAR) begin
          idx <= idx + IDX_W'(1);
          if (label_done) label_count <= '0;
        end
        if (state == S_TERM) foot_idx <= '0;
        if (state == S_FOOT) begin
          foot_idx <= foot_idx + 2'd1;
          if (emit_last) begin
            overflow_seen <= 1'b0;
            label_count   <= '0;
          end
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // label store and output payload
  always_ff @(posedge clk) begin
    if (req_fire && req_data.cmd == CMD_CHAR && req_data.name_char != DOT_CHAR &&
        label_count < CNT_W'(MAX_LABEL)) begin
      label_buffer[label_count[IDX_W-1:0]] <= req_data.name_char;
    end
    if (emit) begin
      rsp_data.out_byte       <= emit_byte;
      rsp_data.record_end     <= emit_last;
      rsp_data.label_overflow <= emit_ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    label_count <= CNT_W'(MAX_LABEL))
    else $error("label count beyond capacity");

  a_record_close: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOOT && emit && emit_last) |=>
      (state == S_IDLE && label_count == '0 && !overflow_seen && rsp_valid &&
       rsp_data.record_end))
    else $error("record end did not clear name state");

  a_ovf_only_end: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_ovf) |-> end_mode)
    else $error("overflow flag on a dot label");

  a_busy_on_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_fire && req_data.cmd == CMD_END) |=> req_stall)
    else $error("end of name not held busy");

endmodule
